@@ sv/assert_macros.svh @@
// Assertion macros shared by the UART register model RTL.
// Depends on a clock named clk and an active-high reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/uart16_pkg.sv @@
// Types, register codes and constants for the 16550-style UART register model.
// No dependencies; used by every module of the block.
package uart16_pkg;

  localparam int RX_FIFO_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_RX    = 2'd2
  } req_e;

  localparam logic [2:0] OFF_DATA = 3'd0;
  localparam logic [2:0] OFF_IER  = 3'd1;
  localparam logic [2:0] OFF_IIR  = 3'd2;
  localparam logic [2:0] OFF_LCR  = 3'd3;
  localparam logic [2:0] OFF_MCR  = 3'd4;
  localparam logic [2:0] OFF_LSR  = 3'd5;
  localparam logic [2:0] OFF_MSR  = 3'd6;
  localparam logic [2:0] OFF_SCR  = 3'd7;

  localparam int LCR_DLAB = 7;
  localparam int IER_RDI  = 0;
  localparam int IER_THRI = 1;
  localparam int LSR_DR   = 0;
  localparam int LSR_THRE = 5;
  localparam int LSR_TEMT = 6;

  localparam logic [7:0] IIR_NONE   = 8'h01;
  localparam logic [7:0] IIR_RX     = 8'h04;
  localparam logic [7:0] IIR_TX     = 8'h02;
  localparam logic [7:0] IIR_FIFO   = 8'hC0;
  localparam logic [7:0] MCR_RESET  = 8'h08;
  localparam logic [7:0] LSR_RESET  = 8'h60;
  localparam logic [7:0] MSR_RESET  = 8'hB0;
  localparam logic [7:0] LSR_TX_IDLE = 8'h60;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } fifo_sts_t;

  typedef struct packed {
    logic       rx_dropped;
    logic       irq_out;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       rdata_valid;
    logic [7:0] rdata;
  } res_t;

  // Interrupt identification: receive data outranks transmitter empty.
  function automatic logic [7:0] iid_calc(input logic [7:0] ier, input logic [7:0] lsr);
    logic [7:0] id;
    id = IIR_NONE;
    if (ier[IER_RDI] && lsr[LSR_DR]) begin
      id = IIR_RX;
    end else if (ier[IER_THRI] && lsr[LSR_TEMT]) begin
      id = IIR_TX;
    end
    return id | IIR_FIFO;
  endfunction

endpackage

@@ sv/uart16_rxfifo.sv @@
// Receive FIFO of the UART model: memory, head/tail pointers and fill count.
// Depends on uart16_pkg and assert_macros.svh; keeps the head entry prefetched.
`include "assert_macros.svh"
module uart16_rxfifo
  import uart16_pkg::*;
#(
  parameter int DEPTH = RX_FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctl_t  ctl,
  input  logic [7:0] wdata,
  output logic [7:0] head_data,
  output fifo_sts_t  sts
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [7:0]       mem [DEPTH];
  logic [IDX_W-1:0] head, head_next, tail, tail_next;
  logic [CNT_W-1:0] count, count_next;

  function automatic logic [IDX_W-1:0] inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    head_next  = ctl.pop ? inc(head) : head;
    tail_next  = ctl.push ? inc(tail) : tail;
    count_next = count;
    if (ctl.push && !ctl.pop) begin
      count_next = count + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      count_next = count - 1'b1;
    end
  end

  assign sts.empty = (count == '0);
  assign sts.full  = (count == CNT_W'(DEPTH));
  assign sts.last  = (count == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // The entry at the next head is read every cycle; a push landing on that
  // very entry is forwarded, as the memory still returns the old contents.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wdata;
    end
    if (ctl.push && (tail == head_next)) begin
      head_data <= wdata;
    end else begin
      head_data <= mem[head_next];
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "rx fifo count beyond depth")
  `ASSERT_IMPLY(a_no_overflow, ctl.push, !sts.full, "push into full rx fifo")
  `ASSERT_IMPLY(a_no_underflow, ctl.pop, !sts.empty, "pop from empty rx fifo")
  `ASSERT_NEXT(a_head_fwd, ctl.push && sts.empty, head_data == $past(wdata), "head entry not forwarded")

endmodule

@@ sv/uart16_core.sv @@
// Register file and access decode of the UART model: DLAB banking, LSR/IIR upkeep.
// Depends on uart16_pkg and assert_macros.svh; drives the receive FIFO controls.
`include "assert_macros.svh"
module uart16_core
  import uart16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [1:0] req_type,
  input  logic [2:0] offset,
  input  logic [7:0] wdata,
  input  fifo_sts_t  fifo_sts,
  input  logic [7:0] head_data,
  output fifo_ctl_t  fifo_ctl,
  output res_t       res
);

  logic [7:0] dll, dlm, ier, fcr, lcr, mcr, lsr, msr, iid, scr;
  logic [7:0] dll_next, dlm_next, ier_next, fcr_next, lcr_next, mcr_next;
  logic [7:0] lsr_next, iid_next, scr_next;
  logic       recompute, dlab, push, pop;

  assign dlab = lcr[LCR_DLAB];

  always_comb begin
    dll_next  = dll;
    dlm_next  = dlm;
    ier_next  = ier;
    fcr_next  = fcr;
    lcr_next  = lcr;
    mcr_next  = mcr;
    lsr_next  = lsr;
    scr_next  = scr;
    recompute = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    res       = '0;
    case (req_e'(req_type))
      REQ_READ: begin
        res.rdata_valid = 1'b1;
        case (offset)
          OFF_DATA: begin
            if (dlab) begin
              res.rdata = dll;
            end else if (fifo_sts.empty) begin
              res.rdata_valid = 1'b0;
            end else begin
              res.rdata = head_data;
              pop       = 1'b1;
              if (fifo_sts.last) begin
                lsr_next[LSR_DR] = 1'b0;
                recompute        = 1'b1;
              end
            end
          end
          OFF_IER: res.rdata = dlab ? dlm : ier;
          OFF_IIR: res.rdata = iid | IIR_FIFO;
          OFF_LCR: res.rdata = lcr;
          OFF_MCR: res.rdata = mcr;
          OFF_LSR: res.rdata = lsr;
          OFF_MSR: res.rdata = msr;
          default: res.rdata = scr;
        endcase
      end
      REQ_WRITE: begin
        case (offset)
          OFF_DATA: begin
            if (dlab) begin
              dll_next = wdata;
            end else begin
              lsr_next     = lsr | LSR_TX_IDLE;
              res.tx_valid = 1'b1;
              res.tx_byte  = wdata;
              recompute    = 1'b1;
            end
          end
          OFF_IER: begin
            if (dlab) begin
              dlm_next = wdata;
            end else begin
              ier_next  = wdata;
              recompute = 1'b1;
            end
          end
          OFF_IIR: fcr_next = wdata;
          OFF_LCR: lcr_next = wdata;
          OFF_MCR: mcr_next = wdata;
          OFF_SCR: scr_next = wdata;
          default: ;
        endcase
      end
      REQ_RX: begin
        if (fifo_sts.full) begin
          res.rx_dropped = 1'b1;
        end else begin
          push             = 1'b1;
          lsr_next[LSR_DR] = 1'b1;
          recompute        = 1'b1;
        end
      end
      default: ;
    endcase
    iid_next    = recompute ? iid_calc(ier_next, lsr_next) : iid;
    res.irq_out = (iid_next[2:0] != IIR_NONE[2:0]);
  end

  assign fifo_ctl.push = fire && push;
  assign fifo_ctl.pop  = fire && pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      dll <= '0;
      dlm <= '0;
      ier <= '0;
      fcr <= '0;
      lcr <= '0;
      mcr <= MCR_RESET;
      lsr <= LSR_RESET;
      msr <= MSR_RESET;
      iid <= IIR_NONE;
      scr <= '0;
    end else if (fire) begin
      dll <= dll_next;
      dlm <= dlm_next;
      ier <= ier_next;
      fcr <= fcr_next;
      lcr <= lcr_next;
      mcr <= mcr_next;
      lsr <= lsr_next;
      iid <= iid_next;
      scr <= scr_next;
    end
  end

  // The modem status never changes in this model; FCR is stored but unused.
  `ASSERT_ALWAYS(a_dr_tracks_fifo, lsr[LSR_DR] == !fifo_sts.empty, "DR out of step with rx fifo")
  `ASSERT_ALWAYS(a_msr_const, msr == MSR_RESET, "modem status changed")
  `ASSERT_NEXT(a_fcr_wr, fire && req_type == REQ_WRITE && offset == OFF_IIR, fcr == $past(wdata), "FCR lost")

endmodule

@@ sv/uart_16550_register_model.sv @@
// Top level of the 16550-style UART register model: input and result stages.
// Depends on uart16_pkg, uart16_core and uart16_rxfifo.
// One beat in gives exactly one beat out. Input beats carry a guest register read, a guest
// register write or a received byte, selected by s_tuser; each is processed combinationally
// between the input register and the result register, so the block sustains one beat per clock
// while the master side accepts results. A beat passes through the input register and then the
// result register before it is offered on the master side. The input register lets one further
// beat be taken while an unconsumed result waits; s_tready then stays low until the result is
// taken. The receive FIFO holds RX_FIFO_DEPTH bytes; a byte arriving when it is full is dropped
// and flagged in the result.
module uart_16550_register_model
  import uart16_pkg::*;
#(
  parameter int RX_FIFO_DEPTH = RX_FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // offset[2:0], wdata[10:3], zero above
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // rdata[7:0], tx_byte[15:8], irq_out[16], rx_dropped[17], zero above
  output logic [1:0]  m_tuser    // rdata_valid[0], tx_valid[1]
);

  logic        in_valid;
  logic [1:0]  in_req;
  logic [2:0]  in_offset;
  logic [7:0]  in_wdata;
  logic        fire;
  res_t        res, res_q;
  fifo_ctl_t   fifo_ctl;
  fifo_sts_t   fifo_sts;
  logic [7:0]  head_data;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req    <= s_tuser;
      in_offset <= s_tdata[2:0];
      in_wdata  <= s_tdata[10:3];
    end
  end

  uart16_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req_type  (in_req),
    .offset    (in_offset),
    .wdata     (in_wdata),
    .fifo_sts  (fifo_sts),
    .head_data (head_data),
    .fifo_ctl  (fifo_ctl),
    .res       (res)
  );

  uart16_rxfifo #(
    .DEPTH (RX_FIFO_DEPTH)
  ) u_rxfifo (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fifo_ctl),
    .wdata     (in_wdata),
    .head_data (head_data),
    .sts       (fifo_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_tdata = {6'd0, res_q.rx_dropped, res_q.irq_out, res_q.tx_byte, res_q.rdata};
  assign m_tuser = {res_q.tx_valid, res_q.rdata_valid};

endmodule

@@ tb/uart_16550_register_model_tb.sv @@
// Self-checking testbench for the 16550-style UART register model: a directed table
// followed by random register traffic, checked against typed-in expectations or an in-bench predictor.
// Depends on uart16_pkg and uart_16550_register_model.
module uart_16550_register_model_tb;
  import uart16_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int DEPTH = RX_FIFO_DEPTH_DEF;
  localparam int DIR_ROWS = 27;
  localparam int RANDOM_ITEMS = 1920;

  typedef struct {
    logic [1:0] req;
    logic [2:0] off;
    logic [7:0] wd;
    int         reps;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  // Predicted register file.
  logic [7:0] dll_q, dlm_q, ier_q, fcr_q, lcr_q, mcr_q, lsr_q, msr_q, iir_q, scr_q;
  logic [7:0] rx_bytes [DEPTH];
  int         rx_rd, rx_wr, rx_cnt;
  logic       irq_q;

  res_t      reg_results_due [$];
  stim_row_t dir_tab [DIR_ROWS];
  int        mismatches;
  int        idle_pct;
  int        stall_pct;

  uart_16550_register_model i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void irq_update();
    logic [7:0] id;
    id = IIR_NONE;
    if (ier_q[IER_RDI] && lsr_q[LSR_DR]) begin
      id = IIR_RX;
    end else if (ier_q[IER_THRI] && lsr_q[LSR_TEMT]) begin
      id = IIR_TX;
    end
    iir_q = id | IIR_FIFO;
    irq_q = (id != IIR_NONE);
  endfunction

  function automatic res_t uart_regs_step(input logic [1:0] req, input logic [2:0] off,
                                          input logic [7:0] wd);
    res_t r;
    logic dlab;
    r = '0;
    dlab = lcr_q[LCR_DLAB];
    if (req == REQ_READ) begin
      r.rdata_valid = 1'b1;
      case (off)
        OFF_DATA: begin
          if (dlab) begin
            r.rdata = dll_q;
          end else if (rx_cnt == 0) begin
            r.rdata_valid = 1'b0;
          end else begin
            r.rdata = rx_bytes[rx_rd];
            rx_rd = (rx_rd + 1) % DEPTH;
            rx_cnt--;
            if (rx_cnt == 0) begin
              lsr_q[LSR_DR] = 1'b0;
              irq_update();
            end
          end
        end
        OFF_IER: r.rdata = dlab ? dlm_q : ier_q;
        OFF_IIR: r.rdata = iir_q | IIR_FIFO;
        OFF_LCR: r.rdata = lcr_q;
        OFF_MCR: r.rdata = mcr_q;
        OFF_LSR: r.rdata = lsr_q;
        OFF_MSR: r.rdata = msr_q;
        default: r.rdata = scr_q;
      endcase
    end else if (req == REQ_WRITE) begin
      case (off)
        OFF_DATA: begin
          if (dlab) begin
            dll_q = wd;
          end else begin
            lsr_q[LSR_TEMT] = 1'b1;
            lsr_q[LSR_THRE] = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_byte = wd;
            irq_update();
          end
        end
        OFF_IER: begin
          if (dlab) begin
            dlm_q = wd;
          end else begin
            ier_q = wd;
            irq_update();
          end
        end
        OFF_IIR: fcr_q = wd;
        OFF_LCR: lcr_q = wd;
        OFF_MCR: mcr_q = wd;
        OFF_SCR: scr_q = wd;
        default: ;
      endcase
    end else if (req == REQ_RX) begin
      if (rx_cnt < DEPTH) begin
        rx_bytes[rx_wr] = wd;
        rx_wr = (rx_wr + 1) % DEPTH;
        rx_cnt++;
        lsr_q[LSR_DR] = 1'b1;
        irq_update();
      end else begin
        r.rx_dropped = 1'b1;
      end
    end
    r.irq_out = irq_q;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [1:0] req, input logic [2:0] off,
                                    input logic [7:0] wd, input int reps, input bit typed,
                                    input logic [7:0] rd, input bit rv, input bit tv,
                                    input logic [7:0] txb, input bit irq);
    stim_row_t s;
    s.req = req;
    s.off = off;
    s.wd = wd;
    s.reps = reps;
    s.typed = typed;
    s.want = '0;
    s.want.rdata = rd;
    s.want.rdata_valid = rv;
    s.want.tx_valid = tv;
    s.want.tx_byte = txb;
    s.want.irq_out = irq;
    return s;
  endfunction

  function automatic void check_field(input string fname, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      mismatches++;
    end
  endfunction

  // Offers one beat after a random gap and books its expected result (typed in or predicted) once accepted.
  task automatic offer_beat(input logic [1:0] req, input logic [2:0] off, input logic [7:0] wd,
                            input bit typed, input res_t want);
    res_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {5'd0, wd, off};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = uart_regs_step(req, off, wd);
    reg_results_due.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (reg_results_due.size() == 0) begin
        $error("result beat arrived with no request outstanding");
        mismatches++;
      end else begin
        want = reg_results_due.pop_front();
        check_field("rdata", want.rdata, m_tdata[7:0]);
        check_field("tx_byte", want.tx_byte, m_tdata[15:8]);
        check_field("irq_out", 8'(want.irq_out), 8'(m_tdata[16]));
        check_field("rx_dropped", 8'(want.rx_dropped), 8'(m_tdata[17]));
        check_field("rdata_valid", 8'(want.rdata_valid), 8'(m_tuser[0]));
        check_field("tx_valid", 8'(want.tx_valid), 8'(m_tuser[1]));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int idle_tab [4];
    int stall_tab [4];
    int burst_left;
    int pick;
    logic [1:0] burst_req;
    logic [1:0] req;
    logic [2:0] off;
    logic [7:0] wd;

    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    burst_left = 0;
    burst_req = REQ_RX;
    idle_tab = '{0, 88, 0, 32};
    stall_tab = '{0, 0, 88, 32};

    dll_q = '0;
    dlm_q = '0;
    ier_q = '0;
    fcr_q = '0;
    lcr_q = '0;
    mcr_q = MCR_RESET;
    lsr_q = LSR_RESET;
    msr_q = MSR_RESET;
    iir_q = IIR_NONE;
    scr_q = '0;
    rx_rd = 0;
    rx_wr = 0;
    rx_cnt = 0;
    irq_q = 1'b0;

    // Rows with an expectation typed in are the reset values and other plain cases.
    dir_tab = '{
      row(REQ_READ,   OFF_LSR,  8'h00, 1,  1, 8'h60, 1, 0, 8'h00, 0),
      row(REQ_READ,   OFF_MSR,  8'h00, 1,  1, 8'hB0, 1, 0, 8'h00, 0),
      row(REQ_READ,   OFF_MCR,  8'h00, 1,  1, 8'h08, 1, 0, 8'h00, 0),
      row(REQ_READ,   OFF_IIR,  8'h00, 1,  1, 8'hC1, 1, 0, 8'h00, 0),
      row(REQ_READ,   OFF_DATA, 8'h00, 1,  1, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_WRITE,  OFF_LSR,  8'hFF, 1,  1, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_WRITE,  OFF_MSR,  8'h00, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_READ,   OFF_LSR,  8'h00, 1,  1, 8'h60, 1, 0, 8'h00, 0),
      row(REQ_WRITE,  OFF_SCR,  8'hFF, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_READ,   OFF_SCR,  8'h00, 1,  1, 8'hFF, 1, 0, 8'h00, 0),
      row(REQ_WRITE,  OFF_IER,  8'h03, 1,  1, 8'h00, 0, 0, 8'h00, 1),
      row(REQ_RX,     OFF_DATA, 8'h00, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_READ,   OFF_IIR,  8'h00, 1,  1, 8'hC4, 1, 0, 8'h00, 1),
      row(REQ_READ,   OFF_DATA, 8'h00, 1,  1, 8'h00, 1, 0, 8'h00, 1),
      row(REQ_WRITE,  OFF_DATA, 8'hFF, 1,  1, 8'h00, 0, 1, 8'hFF, 1),
      // Seventeen arrivals: the last one finds the FIFO full and is dropped.
      row(REQ_RX,     OFF_DATA, 8'hF0, 17, 0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_READ,   OFF_DATA, 8'h00, 3,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_WRITE,  OFF_LCR,  8'h80, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_WRITE,  OFF_DATA, 8'hA5, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_WRITE,  OFF_IER,  8'h5A, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_READ,   OFF_DATA, 8'h00, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_READ,   OFF_IER,  8'h00, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_WRITE,  OFF_LCR,  8'h00, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_WRITE,  OFF_IIR,  8'hC7, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_UNUSED, OFF_SCR,  8'hFF, 1,  0, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_WRITE,  OFF_IER,  8'h00, 1,  1, 8'h00, 0, 0, 8'h00, 0),
      row(REQ_READ,   OFF_LCR,  8'h00, 1,  1, 8'h00, 1, 0, 8'h00, 0)
    };

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      for (int k = 0; k < dir_tab[i].reps; k++) begin
        offer_beat(dir_tab[i].req, dir_tab[i].off, 8'(dir_tab[i].wd + k), dir_tab[i].typed,
                   dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        wd = 8'($urandom_range(255));
        off = 3'($urandom_range(7));
        if (burst_left != 0) begin
          // Runs of arrivals or pops can push the FIFO to full and back to empty.
          burst_left--;
          req = burst_req;
          off = OFF_DATA;
        end else begin
          pick = $urandom_range(99);
          if (pick < 10) begin
            burst_left = $urandom_range(19, 3);
            burst_req = $urandom_range(1) ? REQ_RX : REQ_READ;
            req = burst_req;
            off = OFF_DATA;
          end else if (pick < 30) begin
            req = REQ_RX;
          end else if (pick < 50) begin
            req = REQ_READ;
            off = OFF_DATA;
          end else if (pick < 62) begin
            req = REQ_READ;
          end else if (pick < 70) begin
            req = REQ_WRITE;
            off = OFF_IER;
          end else if (pick < 78) begin
            // Keep the divisor latch closed most of the time so that data reads pop.
            req = REQ_WRITE;
            off = OFF_LCR;
            if ($urandom_range(9) < 7) wd[LCR_DLAB] = 1'b0;
          end else if (pick < 86) begin
            req = REQ_WRITE;
            off = OFF_DATA;
          end else if (pick < 97) begin
            req = REQ_WRITE;
          end else begin
            req = REQ_UNUSED;
          end
        end
        offer_beat(req, off, wd, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (reg_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
